@@ rtl/x86e_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// x86e_pkg
// Shared types and constants for the x86-64 instruction encoder.
// ----------------------------------------------------------------------------
package x86e_pkg;

    // Longest instruction: prefix, REX, opcode, ModRM, SIB and four
    // displacement bytes.
    localparam int MaxBytes = 9;
    localparam int CountW   = $clog2(MaxBytes + 1);

    localparam logic [7:0] RexBase  = 8'h40;
    localparam logic [7:0] RexW     = 8'h08;
    localparam logic [7:0] RexR     = 8'h04;
    localparam logic [7:0] RexX     = 8'h02;
    localparam logic [7:0] RexB     = 8'h01;
    localparam logic [7:0] OpSizePx = 8'h66;
    localparam logic [7:0] OpRet    = 8'hC3;
    localparam logic [7:0] OpPopR   = 8'h58;
    localparam logic [7:0] OpPushR  = 8'h50;
    localparam logic [7:0] OpPopM   = 8'h8F;
    localparam logic [7:0] OpPushM  = 8'hFF;
    localparam logic [7:0] OpMov8   = 8'h88;
    localparam logic [7:0] OpMov    = 8'h89;
    localparam logic [7:0] ModRegReg = 8'hC0;
    localparam logic [7:0] ModDisp32 = 8'h80;
    localparam logic [7:0] ModDisp8  = 8'h40;
    localparam logic [2:0] RmSib     = 3'd4;
    localparam logic [2:0] RmBp      = 3'd5;
    localparam logic [2:0] RegPushM  = 3'd6;
    localparam logic [2:0] RegPopM   = 3'd0;

    typedef enum logic [2:0] {
        CMD_RET      = 3'd0,
        CMD_POP_REG  = 3'd1,
        CMD_POP_MEM  = 3'd2,
        CMD_PUSH_REG = 3'd3,
        CMD_PUSH_MEM = 3'd4,
        CMD_MOV_RR   = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        SIZE_BYTE  = 2'd0,
        SIZE_WORD  = 2'd1,
        SIZE_DWORD = 2'd2,
        SIZE_QWORD = 2'd3
    } size_t_e_t;

    typedef enum logic [1:0] {
        DISP_NONE = 2'd0,
        DISP_8    = 2'd1,
        DISP_32   = 2'd2
    } disp_len_t;

    // One request as captured at the input register.
    typedef struct packed {
        logic [2:0]  command;
        logic [1:0]  op_size;
        logic [3:0]  src_reg;
        logic [3:0]  dst_reg;
        logic        has_base;
        logic [3:0]  base_reg;
        logic        has_index;
        logic [3:0]  index_reg;
        logic [1:0]  scale_code;
        logic [31:0] displacement;
    } req_t;

    // Decoded instruction: every byte that may appear and whether it does.
    typedef struct packed {
        logic        legal;
        logic        prefix_en;
        logic        rex_en;
        logic [7:0]  rex;
        logic [7:0]  opcode;
        logic        modrm_en;
        logic [7:0]  modrm;
        logic        sib_en;
        logic [7:0]  sib;
        disp_len_t   disp_len;
        logic [31:0] disp;
    } dec_t;

endpackage
`default_nettype wire

@@ rtl/x86e_decode.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// x86e_decode
// Works out prefix, REX, opcode, ModRM, SIB and displacement size of one
// request.
// ----------------------------------------------------------------------------
module x86e_decode (
    input  x86e_pkg::req_t req,
    output x86e_pkg::dec_t dec
);

    logic       in_byte;
    logic       has_sib;
    logic       has_disp;
    logic [2:0] base_lo;
    logic [2:0] mem_reg;
    logic [7:0] mem_modrm;
    logic [7:0] mem_sib;
    logic [7:0] mem_rex;
    logic       word_size;

    assign base_lo   = req.base_reg[2:0];
    assign word_size = (req.op_size == x86e_pkg::SIZE_WORD);
    assign in_byte   = (req.displacement[31:7] == '0) || (req.displacement[31:7] == '1);
    assign has_sib   = req.has_index || !req.has_base || (base_lo == x86e_pkg::RmSib)
                       || (req.scale_code != 2'd0);
    assign has_disp  = !req.has_base || (req.displacement != '0)
                       || (base_lo == x86e_pkg::RmBp);
    assign mem_reg   = (x86e_pkg::cmd_t'(req.command) == x86e_pkg::CMD_POP_MEM)
                       ? x86e_pkg::RegPopM : x86e_pkg::RegPushM;

    always_comb
    begin
        mem_modrm = {2'b00, mem_reg, (has_sib ? x86e_pkg::RmSib : base_lo)};
        if (req.has_base)
        begin
            if (!in_byte)
            begin
                mem_modrm = mem_modrm | x86e_pkg::ModDisp32;
            end
            else if (has_disp)
            begin
                mem_modrm = mem_modrm | x86e_pkg::ModDisp8;
            end
        end
    end

    assign mem_sib = {req.scale_code,
                      (req.has_index ? req.index_reg[2:0] : x86e_pkg::RmSib),
                      (req.has_base ? base_lo : x86e_pkg::RmBp)};
    assign mem_rex = x86e_pkg::RexBase
                     | ((req.has_index && req.index_reg[3]) ? x86e_pkg::RexX : 8'h00)
                     | ((req.has_base && req.base_reg[3]) ? x86e_pkg::RexB : 8'h00);

    always_comb
    begin
        dec           = '0;
        dec.disp_len  = x86e_pkg::DISP_NONE;
        dec.disp      = req.displacement;
        dec.sib       = mem_sib;
        case (x86e_pkg::cmd_t'(req.command))
            x86e_pkg::CMD_RET:
            begin
                dec.legal  = 1'b1;
                dec.opcode = x86e_pkg::OpRet;
            end
            x86e_pkg::CMD_POP_REG, x86e_pkg::CMD_PUSH_REG:
            begin
                dec.legal     = 1'b1;
                dec.prefix_en = word_size;
                dec.rex_en    = req.src_reg[3];
                dec.rex       = x86e_pkg::RexBase | x86e_pkg::RexB;
                dec.opcode    = ((x86e_pkg::cmd_t'(req.command) == x86e_pkg::CMD_POP_REG)
                                 ? x86e_pkg::OpPopR : x86e_pkg::OpPushR)
                                | {5'b00000, req.src_reg[2:0]};
            end
            x86e_pkg::CMD_POP_MEM, x86e_pkg::CMD_PUSH_MEM:
            begin
                dec.legal     = 1'b1;
                dec.prefix_en = word_size;
                dec.rex_en    = (mem_rex != x86e_pkg::RexBase);
                dec.rex       = mem_rex;
                dec.opcode    = (x86e_pkg::cmd_t'(req.command) == x86e_pkg::CMD_POP_MEM)
                                ? x86e_pkg::OpPopM : x86e_pkg::OpPushM;
                dec.modrm_en  = 1'b1;
                dec.modrm     = mem_modrm;
                dec.sib_en    = has_sib;
                if (!in_byte || !req.has_base)
                begin
                    dec.disp_len = x86e_pkg::DISP_32;
                end
                else if (has_disp)
                begin
                    dec.disp_len = x86e_pkg::DISP_8;
                end
            end
            x86e_pkg::CMD_MOV_RR:
            begin
                dec.legal     = 1'b1;
                dec.prefix_en = word_size;
                dec.rex_en    = 1'b1;
                dec.rex       = x86e_pkg::RexBase
                                | ((req.op_size == x86e_pkg::SIZE_QWORD) ? x86e_pkg::RexW : 8'h00)
                                | (req.src_reg[3] ? x86e_pkg::RexR : 8'h00)
                                | (req.dst_reg[3] ? x86e_pkg::RexB : 8'h00);
                dec.opcode    = (req.op_size == x86e_pkg::SIZE_BYTE)
                                ? x86e_pkg::OpMov8 : x86e_pkg::OpMov;
                dec.modrm_en  = 1'b1;
                dec.modrm     = x86e_pkg::ModRegReg
                                | {2'b00, req.src_reg[2:0], req.dst_reg[2:0]};
            end
            default:
            begin
                dec.legal = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/x86_64_instruction_encoder_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// x86_64_instruction_encoder_core
// Encodes ret, push, pop and register mov requests into x86-64 machine code.
// ----------------------------------------------------------------------------
// Usage:
// A request transaction is accepted at a rising edge where start is high and
// busy is low. The request fields (command, op_size, registers and the
// base/index/scale/displacement address) are sampled at that edge.
// The encoded bytes leave one per cycle on code_byte, each marked by
// byte_valid for exactly one cycle; last_byte is high on the final byte of
// the instruction. The receiver cannot stall the byte stream.
// A request moves from the input register to the decode register and then
// to the serializer register, which puts its first byte on the ports; each
// move waits while the stage ahead is full. An instruction is from 1 (ret)
// up to 9 bytes long, and the bytes of consecutive instructions follow
// each other with no gap when the next one is already decoded. A new
// request can be taken while earlier ones are still leaving, and the
// one-byte output port sets the rate. busy rises when both pipeline
// registers hold requests and the serializer still has more than one byte
// left. Unused command codes produce no bytes and are dropped at decode.
// Reset clears all valid bits and the serializer byte count; no byte is
// emitted until a request arrives.
// ----------------------------------------------------------------------------
module x86_64_instruction_encoder_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  command,
    input  wire logic [1:0]  op_size,
    input  wire logic [3:0]  src_reg,
    input  wire logic [3:0]  dst_reg,
    input  wire logic        has_base,
    input  wire logic [3:0]  base_reg,
    input  wire logic        has_index,
    input  wire logic [3:0]  index_reg,
    input  wire logic [1:0]  scale_code,
    input  wire logic [31:0] displacement,
    output logic             byte_valid,
    output logic [7:0]       code_byte,
    output logic             last_byte
);

    localparam int MaxBytes = x86e_pkg::MaxBytes;
    localparam int CountW   = x86e_pkg::CountW;

    // Stage 0: captured request.
    logic           req_valid_reg;
    logic           req_valid_next;
    x86e_pkg::req_t req_reg;

    // Stage 1: decoded instruction.
    logic           dec_valid_reg;
    logic           dec_valid_next;
    x86e_pkg::dec_t dec_reg;
    x86e_pkg::dec_t dec_comb;

    // Stage 2: byte serializer.
    logic [7:0]        ser_buf_reg [MaxBytes];
    logic [CountW-1:0] ser_count_reg;
    logic [CountW-1:0] ser_count_next;
    logic [7:0]        asm_buf [MaxBytes];
    logic [CountW-1:0] asm_count;

    logic accept;
    logic ser_load;
    logic dec_advance;
    logic req_advance;

    x86e_decode u_decode (
        .req (req_reg),
        .dec (dec_comb)
    );

    // The serializer takes a new instruction when it is empty or is showing
    // the last byte of the current one, so instructions leave back to back.
    assign ser_load    = dec_valid_reg && (ser_count_reg <= CountW'(1));
    assign dec_advance = !dec_valid_reg || ser_load;
    assign req_advance = req_valid_reg && dec_advance;
    assign busy        = req_valid_reg && !dec_advance;
    assign accept      = start && !busy;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (accept)
        begin
            req_valid_next = 1'b1;
        end
        else if (req_advance)
        begin
            req_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        dec_valid_next = dec_valid_reg;
        if (dec_advance)
        begin
            dec_valid_next = req_valid_reg && dec_comb.legal;
        end
    end

    // Pack the present bytes of the decoded instruction into a dense buffer.
    always_comb
    begin
        logic [CountW-1:0] pos;
        pos = '0;
        for (int i = 0; i < MaxBytes; i++)
        begin
            asm_buf[i] = 8'h00;
        end
        if (dec_reg.prefix_en)
        begin
            asm_buf[pos[3:0]] = x86e_pkg::OpSizePx;
            pos = pos + CountW'(1);
        end
        if (dec_reg.rex_en)
        begin
            asm_buf[pos[3:0]] = dec_reg.rex;
            pos = pos + CountW'(1);
        end
        asm_buf[pos[3:0]] = dec_reg.opcode;
        pos = pos + CountW'(1);
        if (dec_reg.modrm_en)
        begin
            asm_buf[pos[3:0]] = dec_reg.modrm;
            pos = pos + CountW'(1);
        end
        if (dec_reg.sib_en)
        begin
            asm_buf[pos[3:0]] = dec_reg.sib;
            pos = pos + CountW'(1);
        end
        for (int k = 0; k < 4; k++)
        begin
            if (((k == 0) && (dec_reg.disp_len != x86e_pkg::DISP_NONE))
                || (dec_reg.disp_len == x86e_pkg::DISP_32))
            begin
                asm_buf[pos[3:0]] = dec_reg.disp[8*k +: 8];
                pos = pos + CountW'(1);
            end
        end
        asm_count = pos;
    end

    always_comb
    begin
        ser_count_next = ser_count_reg;
        if (ser_load)
        begin
            ser_count_next = asm_count;
        end
        else if (ser_count_reg != '0)
        begin
            ser_count_next = ser_count_reg - CountW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            dec_valid_reg <= 1'b0;
            ser_count_reg <= '0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            dec_valid_reg <= dec_valid_next;
            ser_count_reg <= ser_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.command      <= command;
            req_reg.op_size      <= op_size;
            req_reg.src_reg      <= src_reg;
            req_reg.dst_reg      <= dst_reg;
            req_reg.has_base     <= has_base;
            req_reg.base_reg     <= base_reg;
            req_reg.has_index    <= has_index;
            req_reg.index_reg    <= index_reg;
            req_reg.scale_code   <= scale_code;
            req_reg.displacement <= displacement;
        end
        if (dec_advance)
        begin
            dec_reg <= dec_comb;
        end
        if (ser_load)
        begin
            for (int i = 0; i < MaxBytes; i++)
            begin
                ser_buf_reg[i] <= asm_buf[i];
            end
        end
        else
        begin
            for (int i = 0; i < MaxBytes - 1; i++)
            begin
                ser_buf_reg[i] <= ser_buf_reg[i + 1];
            end
        end
    end

    assign byte_valid = (ser_count_reg != '0);
    assign code_byte  = ser_buf_reg[0];
    assign last_byte  = (ser_count_reg == CountW'(1));

    // The bytes of one instruction leave in consecutive cycles.
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && !last_byte) |=> byte_valid)
        else $error("instruction byte stream broke before its last byte");

    // The serializer never holds more than the longest instruction.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        ser_count_reg <= CountW'(MaxBytes))
        else $error("serializer byte count out of range");

    // An accepted transaction is always captured in the input register.
    a_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> req_valid_reg)
        else $error("accepted request not captured");

    // A decoded instruction waiting on the serializer holds its contents.
    a_dec_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (dec_valid_reg && !ser_load) |=> (dec_valid_reg && $stable(dec_reg)))
        else $error("stalled decode stage changed");

endmodule
`default_nettype wire

@@ tb/x86_64_instruction_encoder_core_test.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// x86_64_instruction_encoder_core_test
// Self-checking testbench for the x86-64 instruction encoder. Each accepted
// request transaction is run through a behavioral encoder in the bench. That
// encoder queues the bytes the block must emit. Each strobed output byte is
// checked against the oldest queued byte and its last-byte flag. A directed
// pass covers every command and the addressing corner cases. A random pass
// then sends bursts of requests with random gaps between them.
// ----------------------------------------------------------------------------
module x86_64_instruction_encoder_core_test;

    // Command codes the block does not define. They must produce no bytes.
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    localparam int RandomItems  = 360;
    // Idle time after the last owed byte, to watch for stray bytes.
    localparam int DrainCycles  = 24;
    localparam int CycleLimit   = 200000;

    typedef struct {
        logic [7:0] code;
        logic       is_last;
    } code_byte_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  command;
    logic [1:0]  op_size;
    logic [3:0]  src_reg;
    logic [3:0]  dst_reg;
    logic        has_base;
    logic [3:0]  base_reg;
    logic        has_index;
    logic [3:0]  index_reg;
    logic [1:0]  scale_code;
    logic [31:0] displacement;
    logic        byte_valid;
    logic [7:0]  code_byte;
    logic        last_byte;

    // Bytes that the encoder still owes, oldest first.
    code_byte_t pending_bytes[$];
    int         error_count = 0;
    int         cycle_count = 0;

    x86_64_instruction_encoder_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .op_size      (op_size),
        .src_reg      (src_reg),
        .dst_reg      (dst_reg),
        .has_base     (has_base),
        .base_reg     (base_reg),
        .has_index    (has_index),
        .index_reg    (index_reg),
        .scale_code   (scale_code),
        .displacement (displacement),
        .byte_valid   (byte_valid),
        .code_byte    (code_byte),
        .last_byte    (last_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Behavioral encoder. It appends the bytes of one instruction to
    // pending_bytes and flags the final one. Unused commands add nothing.
    // ------------------------------------------------------------------------
    function automatic void queue_encoding(input x86e_pkg::req_t r);
        logic [7:0] enc[$];
        logic [7:0] rex;
        logic [2:0] reg_field;
        logic       has_sib;
        logic       has_disp;
        logic       in_byte;
        logic [1:0] mod_bits;
        logic [2:0] rm_bits;
        logic [2:0] index_bits;
        logic [2:0] base_bits;

        rex = x86e_pkg::RexBase;
        case (r.command)
            x86e_pkg::CMD_RET:
            begin
                enc.push_back(x86e_pkg::OpRet);
            end
            x86e_pkg::CMD_POP_REG, x86e_pkg::CMD_PUSH_REG:
            begin
                if (r.op_size == x86e_pkg::SIZE_WORD)
                    enc.push_back(x86e_pkg::OpSizePx);
                // The opcode follows the REX byte for the upper registers too.
                if (r.src_reg[3])
                    enc.push_back(x86e_pkg::RexBase | x86e_pkg::RexB);
                enc.push_back((r.command == x86e_pkg::CMD_POP_REG
                               ? x86e_pkg::OpPopR : x86e_pkg::OpPushR)
                              + {5'd0, r.src_reg[2:0]});
            end
            x86e_pkg::CMD_POP_MEM, x86e_pkg::CMD_PUSH_MEM:
            begin
                if (r.has_index && r.index_reg[3])
                    rex = rex | x86e_pkg::RexX;
                if (r.has_base && r.base_reg[3])
                    rex = rex | x86e_pkg::RexB;
                if (r.op_size == x86e_pkg::SIZE_WORD)
                    enc.push_back(x86e_pkg::OpSizePx);
                if (rex != x86e_pkg::RexBase)
                    enc.push_back(rex);
                enc.push_back(r.command == x86e_pkg::CMD_POP_MEM
                              ? x86e_pkg::OpPopM : x86e_pkg::OpPushM);

                reg_field = (r.command == x86e_pkg::CMD_POP_MEM)
                            ? x86e_pkg::RegPopM : x86e_pkg::RegPushM;
                in_byte   = (r.displacement <= 32'h0000_007F)
                         || (r.displacement >= 32'hFFFF_FF80);
                has_sib   = r.has_index || !r.has_base
                         || r.base_reg[2:0] == x86e_pkg::RmSib || r.scale_code != 2'd0;
                has_disp  = !r.has_base || r.displacement != 32'd0
                         || r.base_reg[2:0] == x86e_pkg::RmBp;

                // Without a base, mod stays 00 and the SIB base field 101
                // selects a bare 32-bit displacement.
                if (!r.has_base)
                    mod_bits = 2'b00;
                else if (!in_byte)
                    mod_bits = 2'b10;
                else if (has_disp)
                    mod_bits = 2'b01;
                else
                    mod_bits = 2'b00;
                rm_bits = has_sib ? x86e_pkg::RmSib : r.base_reg[2:0];
                enc.push_back({mod_bits, reg_field, rm_bits});

                if (has_sib)
                begin
                    index_bits = r.has_index ? r.index_reg[2:0] : 3'd4;
                    base_bits  = r.has_base ? r.base_reg[2:0] : x86e_pkg::RmBp;
                    enc.push_back({r.scale_code, index_bits, base_bits});
                end

                if (!in_byte || !r.has_base)
                begin
                    enc.push_back(r.displacement[7:0]);
                    enc.push_back(r.displacement[15:8]);
                    enc.push_back(r.displacement[23:16]);
                    enc.push_back(r.displacement[31:24]);
                end
                else if (has_disp)
                begin
                    enc.push_back(r.displacement[7:0]);
                end
            end
            x86e_pkg::CMD_MOV_RR:
            begin
                if (r.op_size == x86e_pkg::SIZE_QWORD)
                    rex = rex | x86e_pkg::RexW;
                if (r.src_reg[3])
                    rex = rex | x86e_pkg::RexR;
                if (r.dst_reg[3])
                    rex = rex | x86e_pkg::RexB;
                if (r.op_size == x86e_pkg::SIZE_WORD)
                    enc.push_back(x86e_pkg::OpSizePx);
                enc.push_back(rex);
                enc.push_back(r.op_size == x86e_pkg::SIZE_BYTE
                              ? x86e_pkg::OpMov8 : x86e_pkg::OpMov);
                enc.push_back(x86e_pkg::ModRegReg
                              | {2'b00, r.src_reg[2:0], r.dst_reg[2:0]});
            end
            default:
            begin
            end
        endcase

        foreach (enc[i])
            pending_bytes.push_back('{code: enc[i], is_last: (i == enc.size() - 1)});
    endfunction

    // ------------------------------------------------------------------------
    // Request builders.
    // ------------------------------------------------------------------------
    function automatic x86e_pkg::req_t reg_request(input logic [2:0] cmd,
                                                   input logic [1:0] size,
                                                   input logic [3:0] src,
                                                   input logic [3:0] dst);
        x86e_pkg::req_t r;

        r              = '0;
        r.command      = cmd;
        r.op_size      = size;
        r.src_reg      = src;
        r.dst_reg      = dst;
        // The address fields are ignored by these commands, so fill them
        // with junk.
        r.has_base     = 1'($urandom_range(0, 1));
        r.base_reg     = 4'($urandom_range(0, 15));
        r.has_index    = 1'($urandom_range(0, 1));
        r.index_reg    = 4'($urandom_range(0, 15));
        r.scale_code   = 2'($urandom_range(0, 3));
        r.displacement = $urandom();
        return r;
    endfunction

    function automatic x86e_pkg::req_t mem_request(input logic [2:0] cmd,
                                                   input logic [1:0] size,
                                                   input logic base_on,
                                                   input logic [3:0] base,
                                                   input logic index_on,
                                                   input logic [3:0] index,
                                                   input logic [1:0] scale,
                                                   input logic [31:0] disp);
        x86e_pkg::req_t r;

        r              = reg_request(cmd, size, 4'($urandom_range(0, 15)),
                                     4'($urandom_range(0, 15)));
        r.has_base     = base_on;
        r.base_reg     = base;
        r.has_index    = index_on;
        r.index_reg    = index;
        r.scale_code   = scale;
        r.displacement = disp;
        return r;
    endfunction

    // Random request. Memory operands get most of the weight because they
    // carry nearly all of the encoding decisions.
    function automatic x86e_pkg::req_t random_request();
        x86e_pkg::req_t r;
        int   pick;
        logic [7:0] low_byte;

        r        = reg_request(x86e_pkg::CMD_RET, 2'($urandom_range(0, 3)),
                               4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        pick     = $urandom_range(0, 99);
        if (pick < 5)
            r.command = x86e_pkg::CMD_RET;
        else if (pick < 15)
            r.command = x86e_pkg::CMD_POP_REG;
        else if (pick < 45)
            r.command = x86e_pkg::CMD_POP_MEM;
        else if (pick < 55)
            r.command = x86e_pkg::CMD_PUSH_REG;
        else if (pick < 85)
            r.command = x86e_pkg::CMD_PUSH_MEM;
        else if (pick < 97)
            r.command = x86e_pkg::CMD_MOV_RR;
        else
            r.command = ($urandom_range(0, 1) != 0) ? CMD_SPARE_6 : CMD_SPARE_7;

        r.has_base  = ($urandom_range(0, 6) != 0);
        r.has_index = ($urandom_range(0, 1) != 0);
        // Mostly no scale, so the plain ModRM forms without a SIB byte
        // come up often.
        r.scale_code = ($urandom_range(0, 1) != 0) ? 2'd0 : 2'($urandom_range(0, 3));

        low_byte = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
            0:       r.displacement = 32'd0;
            1:       r.displacement = {{24{low_byte[7]}}, low_byte};
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       r.displacement = 32'hFFFF_FF7F;
                    1:       r.displacement = 32'hFFFF_FF80;
                    2:       r.displacement = 32'h0000_007F;
                    default: r.displacement = 32'h0000_0080;
                endcase
            end
            default: r.displacement = $urandom();
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender. Called at a rising edge. It drives one request and holds it
    // until the block takes the transaction, then queues the predicted
    // bytes. start is left high so that back-to-back requests need no dip.
    // ------------------------------------------------------------------------
    task automatic send_request(input x86e_pkg::req_t r);
        start        <= 1'b1;
        command      <= r.command;
        op_size      <= r.op_size;
        src_reg      <= r.src_reg;
        dst_reg      <= r.dst_reg;
        has_base     <= r.has_base;
        base_reg     <= r.base_reg;
        has_index    <= r.has_index;
        index_reg    <= r.index_reg;
        scale_code   <= r.scale_code;
        displacement <= r.displacement;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        queue_encoding(r);
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Output checker. Every strobed byte is compared with the oldest byte
    // still owed. An X on the strobe counts as a strobe and fails.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        code_byte_t want;

        if (rst_n && byte_valid !== 1'b0)
        begin
            if (pending_bytes.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected byte: expected none, got %02h last %0b",
                         $time, code_byte, last_byte);
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (code_byte !== want.code || last_byte !== want.is_last)
                begin
                    error_count++;
                    $display("%0t: byte mismatch: expected %02h last %0b, got %02h last %0b",
                             $time, want.code, want.is_last, code_byte, last_byte);
                end
            end
        end
    end

    // Watchdog for a block that hangs or stops emitting bytes.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CycleLimit)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------------

    // Ret is one byte no matter what the other fields hold.
    task automatic test_return();
        send_request(reg_request(x86e_pkg::CMD_RET, x86e_pkg::SIZE_DWORD, 4'd3, 4'd9));
        send_request(mem_request(x86e_pkg::CMD_RET, x86e_pkg::SIZE_WORD, 1'b1, 4'd15,
                                 1'b1, 4'd15, 2'd3, 32'hFFFF_FFFF));
    endtask

    // Register push and pop, with and without the word prefix and the REX
    // byte. The opcode must follow REX for the upper registers.
    task automatic test_register_push_pop();
        send_request(reg_request(x86e_pkg::CMD_POP_REG, x86e_pkg::SIZE_DWORD, 4'd0, 4'd0));
        send_request(reg_request(x86e_pkg::CMD_POP_REG, x86e_pkg::SIZE_WORD, 4'd15, 4'd15));
        send_request(reg_request(x86e_pkg::CMD_PUSH_REG, x86e_pkg::SIZE_BYTE, 4'd8, 4'd0));
        send_request(reg_request(x86e_pkg::CMD_PUSH_REG, x86e_pkg::SIZE_QWORD, 4'd7, 4'd15));
    endtask

    // Addressing corner cases for memory push and pop.
    task automatic test_memory_operands();
        // No base and no index: mod 00, SIB base 101, 32-bit displacement.
        send_request(mem_request(x86e_pkg::CMD_POP_MEM, x86e_pkg::SIZE_QWORD, 1'b0, 4'd7,
                                 1'b0, 4'd0, 2'd0, 32'h8000_0000));
        // A stack-pointer base always needs a SIB byte.
        send_request(mem_request(x86e_pkg::CMD_PUSH_MEM, x86e_pkg::SIZE_DWORD, 1'b1, 4'd4,
                                 1'b0, 4'd0, 2'd0, 32'd0));
        // A base with low bits 101 always carries a displacement, even zero.
        send_request(mem_request(x86e_pkg::CMD_PUSH_MEM, x86e_pkg::SIZE_DWORD, 1'b1, 4'd13,
                                 1'b0, 4'd0, 2'd0, 32'd0));
        send_request(mem_request(x86e_pkg::CMD_PUSH_MEM, x86e_pkg::SIZE_BYTE, 1'b1, 4'd5,
                                 1'b0, 4'd0, 2'd0, 32'd0));
        // Upper base and index with the word prefix and the smallest 8-bit
        // displacement.
        send_request(mem_request(x86e_pkg::CMD_POP_MEM, x86e_pkg::SIZE_WORD, 1'b1, 4'd12,
                                 1'b1, 4'd15, 2'd3, 32'hFFFF_FF80));
        // Both ends of the 8-bit range and one step past each.
        send_request(mem_request(x86e_pkg::CMD_PUSH_MEM, x86e_pkg::SIZE_DWORD, 1'b1, 4'd1,
                                 1'b0, 4'd0, 2'd0, 32'h0000_007F));
        send_request(mem_request(x86e_pkg::CMD_POP_MEM, x86e_pkg::SIZE_DWORD, 1'b1, 4'd9,
                                 1'b0, 4'd0, 2'd0, 32'h0000_0080));
        send_request(mem_request(x86e_pkg::CMD_PUSH_MEM, x86e_pkg::SIZE_QWORD, 1'b1, 4'd15,
                                 1'b0, 4'd0, 2'd0, 32'hFFFF_FF7F));
        // Scale given without an index: SIB with index field 100.
        send_request(mem_request(x86e_pkg::CMD_POP_MEM, x86e_pkg::SIZE_BYTE, 1'b1, 4'd3,
                                 1'b0, 4'd9, 2'd2, 32'h7FFF_FFFF));
        // Index register 4 goes through as given and reads as no index.
        send_request(mem_request(x86e_pkg::CMD_PUSH_MEM, x86e_pkg::SIZE_DWORD, 1'b1, 4'd6,
                                 1'b1, 4'd4, 2'd1, 32'd5));
        // Index without a base.
        send_request(mem_request(x86e_pkg::CMD_POP_MEM, x86e_pkg::SIZE_DWORD, 1'b0, 4'd0,
                                 1'b1, 4'd11, 2'd2, 32'hFFFF_FFFF));
    endtask

    // Register moves at every operand size.
    task automatic test_register_moves();
        send_request(reg_request(x86e_pkg::CMD_MOV_RR, x86e_pkg::SIZE_BYTE, 4'd15, 4'd0));
        send_request(reg_request(x86e_pkg::CMD_MOV_RR, x86e_pkg::SIZE_WORD, 4'd0, 4'd15));
        send_request(reg_request(x86e_pkg::CMD_MOV_RR, x86e_pkg::SIZE_DWORD, 4'd9, 4'd10));
        send_request(reg_request(x86e_pkg::CMD_MOV_RR, x86e_pkg::SIZE_QWORD, 4'd15, 4'd15));
    endtask

    // Unused command codes are taken but produce nothing. The requests
    // around them check that they leave no trace in the byte stream.
    task automatic test_unused_commands();
        send_request(reg_request(CMD_SPARE_6, x86e_pkg::SIZE_WORD, 4'd15, 4'd15));
        send_request(reg_request(x86e_pkg::CMD_RET, x86e_pkg::SIZE_BYTE, 4'd0, 4'd0));
        send_request(reg_request(CMD_SPARE_7, x86e_pkg::SIZE_QWORD, 4'd8, 4'd8));
    endtask

    // ------------------------------------------------------------------------
    // Random traffic. Requests go out in bursts of random length. Most
    // bursts are followed by a random gap, so pauses fall at every point of
    // an instruction's byte stream. Some bursts run straight into the next.
    // ------------------------------------------------------------------------
    task automatic test_random_traffic();
        x86e_pkg::req_t r;
        int   encoded;
        int   burst_left;

        encoded    = 0;
        burst_left = $urandom_range(1, 24);
        while (encoded < RandomItems)
        begin
            r = random_request();
            send_request(r);
            // Ignored commands do not count toward the total.
            if (r.command <= x86e_pkg::CMD_MOV_RR)
                encoded++;
            burst_left--;
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 3) != 0)
                    idle_cycles($urandom_range(1, 12));
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n        <= 1'b0;
        start        <= 1'b0;
        command      <= x86e_pkg::CMD_RET;
        op_size      <= x86e_pkg::SIZE_BYTE;
        src_reg      <= 4'd0;
        dst_reg      <= 4'd0;
        has_base     <= 1'b0;
        base_reg     <= 4'd0;
        has_index    <= 1'b0;
        index_reg    <= 4'd0;
        scale_code   <= 2'd0;
        displacement <= 32'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_return();
        test_register_push_pop();
        test_memory_operands();
        test_register_moves();
        test_unused_commands();
        test_random_traffic();

        // Let the pipeline drain. Then watch a while longer for stray bytes.
        start <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire
